### rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants for the spatial eccentricity moments unit
// ----------------------------------------------------------------------------
package sem_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } sem_op_e;

  localparam int unsigned ArithW = 64;
  localparam logic [17:0] AREA_FACTOR_RESET = 18'd205887;
  localparam logic [63:0] VAR_MAX = 64'd1073741823;
  localparam logic [63:0] COV_MAX = 64'd1073741823;
  localparam logic [63:0] COV_MIN_MAG = 64'd1073741824;
  localparam logic [63:0] ECC_MAX = 64'd32767;
  localparam int unsigned ECC_SHIFT = 15;
  localparam int unsigned AREA_SHIFT = 16;
  localparam int unsigned COV_TERM_SHIFT = 2;
  localparam logic [63:0] SQRT_FIRST_BIT = 64'h4000_0000_0000_0000;
  localparam logic [6:0] DIV_STEPS = 7'd64;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

### rtl/core/sem_arith.sv
// ----------------------------------------------------------------------------
// sem_arith
// iterative multiply, divide and square root unit, one step per cycle
// ----------------------------------------------------------------------------
module sem_arith (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sem_pkg::sem_op_e op_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  import sem_pkg::*;

  logic        busy_q, done_q;
  sem_op_e     op_q;
  logic [63:0] x_q, y_q, acc_q, bit_q, res_q;
  logic [6:0]  cnt_q;

  logic [63:0] x_d, y_d, acc_d, bit_d, result;
  logic [6:0]  cnt_d;
  logic        finish;
  logic [64:0] div_r, div_sub;
  logic        div_ge;
  logic [63:0] sq_t;
  logic        sq_ge;

  always_comb begin
    div_r   = {acc_q, x_q[63]};
    div_sub = div_r - {1'b0, y_q};
    div_ge  = div_r >= {1'b0, y_q};
    sq_t    = acc_q + bit_q;
    sq_ge   = x_q >= sq_t;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    bit_d   = bit_q;
    cnt_d   = cnt_q;
    finish  = 1'b1;
    result  = acc_q;
    case (op_q)
      OP_MUL: begin
        finish = (y_q == '0);
        acc_d  = acc_q + (y_q[0] ? x_q : '0);
        x_d    = x_q << 1;
        y_d    = y_q >> 1;
      end
      OP_DIV: begin
        finish = (cnt_q == '0);
        cnt_d  = cnt_q - 7'd1;
        x_d    = {x_q[62:0], div_ge};
        acc_d  = div_ge ? div_sub[63:0] : div_r[63:0];
        result = x_q;
      end
      OP_SQRT: begin
        finish = (bit_q == '0);
        if (sq_ge) begin
          x_d   = x_q - sq_t;
          acc_d = (acc_q >> 1) + bit_q;
        end else begin
          acc_d = acc_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      default: finish = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !finish;
      done_q <= finish;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_i;
      x_q   <= a_i;
      y_q   <= b_i;
      acc_q <= '0;
      bit_q <= SQRT_FIRST_BIT;
      cnt_q <= DIV_STEPS;
    end else if (busy_q) begin
      if (finish) begin
        res_q <= result;
      end else begin
        x_q   <= x_d;
        y_q   <= y_d;
        acc_q <= acc_d;
        bit_q <= bit_d;
        cnt_q <= cnt_d;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### rtl/core/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// point accumulator, closes a set on the last point and hands its sums on
// ----------------------------------------------------------------------------
module sem_front #(
  parameter int unsigned MAX_POINTS = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [15:0]                   x_i,
  input  logic signed [15:0]                   y_i,
  input  logic                                 last_i,
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output logic [$clog2(MAX_POINTS+1)-1:0]      n_o,
  output logic signed [16+$clog2(MAX_POINTS+1)-1:0] sx_o,
  output logic signed [16+$clog2(MAX_POINTS+1)-1:0] sy_o,
  output logic signed [32+$clog2(MAX_POINTS+1)-1:0] sxx_o,
  output logic signed [32+$clog2(MAX_POINTS+1)-1:0] syy_o,
  output logic signed [32+$clog2(MAX_POINTS+1)-1:0] sxy_o,
  output logic                                 drop_o
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 16 + CW;
  localparam int unsigned PW = 32 + CW;

  logic [CW-1:0]        n_q, n_d;
  logic signed [SW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [PW-1:0] sxx_q, sxx_d, syy_q, syy_d, sxy_q, sxy_d;
  logic                 drop_q, drop_d;
  logic signed [31:0]   pxx, pyy, pxy;
  logic                 room, take;

  assign pxx  = x_i * x_i;
  assign pyy  = y_i * y_i;
  assign pxy  = x_i * y_i;
  assign room = n_q < CW'(MAX_POINTS);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    n_d    = n_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    sxx_d  = sxx_q;
    syy_d  = syy_q;
    sxy_d  = sxy_q;
    drop_d = drop_q;
    if (room) begin
      n_d   = n_q + CW'(1);
      sx_d  = sx_q + SW'(x_i);
      sy_d  = sy_q + SW'(y_i);
      sxx_d = sxx_q + PW'(pxx);
      syy_d = syy_q + PW'(pyy);
      sxy_d = sxy_q + PW'(pxy);
    end else begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      sx_q   <= '0;
      sy_q   <= '0;
      sxx_q  <= '0;
      syy_q  <= '0;
      sxy_q  <= '0;
      drop_q <= 1'b0;
    end else if (take) begin
      if (last_i) begin
        n_q    <= '0;
        sx_q   <= '0;
        sy_q   <= '0;
        sxx_q  <= '0;
        syy_q  <= '0;
        sxy_q  <= '0;
        drop_q <= 1'b0;
      end else begin
        n_q    <= n_d;
        sx_q   <= sx_d;
        sy_q   <= sy_d;
        sxx_q  <= sxx_d;
        syy_q  <= syy_d;
        sxy_q  <= sxy_d;
        drop_q <= drop_d;
      end
    end
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = take && last_i;
  assign n_o          = n_d;
  assign sx_o         = sx_d;
  assign sy_o         = sy_d;
  assign sxx_o        = sxx_d;
  assign syy_o        = syy_d;
  assign sxy_o        = sxy_d;
  assign drop_o       = drop_d;

endmodule

### rtl/core/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// two entry queue of closed sets between accumulator and solver
// ----------------------------------------------------------------------------
module sem_queue #(
  parameter int unsigned DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);
  import sem_pkg::*;

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/core/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// per set solver: moments, eccentricities and areas on a shared iterative unit
// ----------------------------------------------------------------------------
module sem_back #(
  parameter int unsigned MAX_POINTS = 512
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      set_valid_i,
  output logic                                      set_ready_o,
  input  logic [$clog2(MAX_POINTS+1)-1:0]           n_i,
  input  logic signed [16+$clog2(MAX_POINTS+1)-1:0] sx_i,
  input  logic signed [16+$clog2(MAX_POINTS+1)-1:0] sy_i,
  input  logic signed [32+$clog2(MAX_POINTS+1)-1:0] sxx_i,
  input  logic signed [32+$clog2(MAX_POINTS+1)-1:0] syy_i,
  input  logic signed [32+$clog2(MAX_POINTS+1)-1:0] sxy_i,
  input  logic                                      drop_i,
  input  logic [17:0]                               area_factor_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [29:0]                               var_x_o,
  output logic [29:0]                               var_y_o,
  output logic signed [30:0]                        cov_xy_o,
  output logic signed [15:0]                        ecc_reaction_o,
  output logic [14:0]                               ecc_participant_o,
  output logic [31:0]                               area_reaction_o,
  output logic [31:0]                               area_participant_o,
  output logic [9:0]                                point_count_o,
  output logic                                      degenerate_o,
  output logic                                      overflow_o
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 16 + CW;
  localparam int unsigned PW = 32 + CW;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NN, ST_XA, ST_XB, ST_XD, ST_YA, ST_YB, ST_YD, ST_CA, ST_CB, ST_CD,
    ST_CC, ST_VV, ST_ER, ST_DD, ST_EPS, ST_EPD, ST_ARS, ST_ARM, ST_APS, ST_APM, ST_OUT
  } state_e;

  state_e               state_q;
  logic                 run_q;
  logic [CW-1:0]        n_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic signed [PW-1:0] sxx_q, syy_q, sxy_q;
  logic                 drop_q, degen_q;
  logic [63:0]          n2_q, cc_q, vv_q, dd_q, root_q;
  logic signed [63:0]   pa_q, num_q;
  logic [29:0]          vx_q, vy_q;
  logic signed [30:0]   c_q;
  logic signed [15:0]   er_q;
  logic [14:0]          ep_q;
  logic [31:0]          ar_q, ap_q;

  logic                 out_valid_q;
  logic [29:0]          ovx_q, ovy_q;
  logic signed [30:0]   oc_q;
  logic signed [15:0]   oer_q;
  logic [14:0]          oep_q;
  logic [31:0]          oar_q, oap_q;
  logic [9:0]           ocnt_q;
  logic                 odeg_q, odrop_q;

  logic                 start, done;
  sem_op_e              op;
  logic [63:0]          opa, opb, res, res_neg, sum64, d64, cmag;
  logic signed [63:0]   rad_pp;
  logic [31:0]          area_sat;
  logic [CW+9:0]        n_ext;

  sem_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (done),
    .res_o   (res)
  );

  assign sum64    = 64'(vx_q) + 64'(vy_q);
  assign d64      = (vx_q > vy_q) ? 64'(vx_q - vy_q) : 64'(vy_q - vx_q);
  assign cmag     = abs64(64'(c_q));
  assign rad_pp   = $signed(vv_q) - $signed(cc_q);
  assign res_neg  = 64'(-$signed(res));
  assign area_sat = (res[63:48] != '0) ? 32'hFFFF_FFFF : res[47:16];
  assign n_ext    = {10'd0, n_q};
  assign start    = !run_q && state_q != ST_IDLE && state_q != ST_OUT;
  assign set_ready_o = state_q == ST_IDLE;

  always_comb begin
    op  = OP_MUL;
    opa = 64'(n_q);
    opb = 64'(n_q);
    case (state_q)
      ST_XA:  opb = 64'(sxx_q);
      ST_XB: begin
        opa = abs64(64'(sx_q));
        opb = abs64(64'(sx_q));
      end
      ST_XD, ST_YD, ST_CD: begin
        op  = OP_DIV;
        opa = abs64(num_q);
        opb = n2_q;
      end
      ST_YA:  opb = 64'(syy_q);
      ST_YB: begin
        opa = abs64(64'(sy_q));
        opb = abs64(64'(sy_q));
      end
      ST_CA:  opb = abs64(64'(sxy_q));
      ST_CB: begin
        opa = abs64(64'(sx_q));
        opb = abs64(64'(sy_q));
      end
      ST_CC: begin
        opa = cmag;
        opb = cmag;
      end
      ST_VV: begin
        opa = 64'(vx_q);
        opb = 64'(vy_q);
      end
      ST_ER: begin
        op  = OP_DIV;
        opa = d64 << ECC_SHIFT;
        opb = sum64;
      end
      ST_DD: begin
        opa = d64;
        opb = d64;
      end
      ST_EPS: begin
        op  = OP_SQRT;
        opa = dd_q + (cc_q << COV_TERM_SHIFT);
      end
      ST_EPD: begin
        op  = OP_DIV;
        opa = root_q << ECC_SHIFT;
        opb = sum64;
      end
      ST_ARS: begin
        op  = OP_SQRT;
        opa = vv_q;
      end
      ST_APS: begin
        op  = OP_SQRT;
        opa = 64'(rad_pp);
      end
      ST_ARM, ST_APM: begin
        opa = root_q;
        opb = 64'(area_factor_i);
      end
      default: op = OP_MUL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (set_valid_i) state_q <= ST_NN;
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          if (!run_q) begin
            run_q <= 1'b1;
          end else if (done) begin
            run_q <= 1'b0;
            case (state_q)
              ST_NN:  state_q <= ST_XA;
              ST_XA:  state_q <= ST_XB;
              ST_XB:  state_q <= ST_XD;
              ST_XD:  state_q <= ST_YA;
              ST_YA:  state_q <= ST_YB;
              ST_YB:  state_q <= ST_YD;
              ST_YD:  state_q <= ST_CA;
              ST_CA:  state_q <= ST_CB;
              ST_CB:  state_q <= ST_CD;
              ST_CD:  state_q <= ST_CC;
              ST_CC:  state_q <= ST_VV;
              ST_VV:  state_q <= (sum64 == '0) ? ST_ARS : ST_ER;
              ST_ER:  state_q <= ST_DD;
              ST_DD:  state_q <= ST_EPS;
              ST_EPS: state_q <= ST_EPD;
              ST_EPD: state_q <= ST_ARS;
              ST_ARS: state_q <= ST_ARM;
              ST_ARM: state_q <= (rad_pp > 0) ? ST_APS : ST_OUT;
              ST_APS: state_q <= ST_APM;
              ST_APM: state_q <= ST_OUT;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (set_valid_i) begin
          n_q    <= n_i;
          sx_q   <= sx_i;
          sy_q   <= sy_i;
          sxx_q  <= sxx_i;
          syy_q  <= syy_i;
          sxy_q  <= sxy_i;
          drop_q <= drop_i;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ovx_q   <= vx_q;
          ovy_q   <= vy_q;
          oc_q    <= c_q;
          oer_q   <= er_q;
          oep_q   <= ep_q;
          oar_q   <= ar_q;
          oap_q   <= ap_q;
          ocnt_q  <= n_ext[9:0];
          odeg_q  <= degen_q;
          odrop_q <= drop_q;
        end
      end
      default: begin
        if (run_q && done) begin
          case (state_q)
            ST_NN:  n2_q <= res;
            ST_XA, ST_YA: pa_q <= $signed(res);
            ST_XB, ST_YB: num_q <= pa_q - $signed(res);
            ST_XD:  vx_q <= (res > VAR_MAX) ? VAR_MAX[29:0] : res[29:0];
            ST_YD:  vy_q <= (res > VAR_MAX) ? VAR_MAX[29:0] : res[29:0];
            ST_CA:  pa_q <= sxy_q[PW-1] ? $signed(res_neg) : $signed(res);
            ST_CB:  num_q <= pa_q - ((sx_q[SW-1] ^ sy_q[SW-1]) ? $signed(res_neg)
                                                                : $signed(res));
            ST_CD: begin
              if (num_q[63]) begin
                c_q <= (res > COV_MIN_MAG) ? 31'(-$signed(COV_MIN_MAG)) : res_neg[30:0];
              end else begin
                c_q <= (res > COV_MAX) ? COV_MAX[30:0] : res[30:0];
              end
            end
            ST_CC:  cc_q <= res;
            ST_VV: begin
              vv_q    <= res;
              degen_q <= sum64 == '0;
              er_q    <= '0;
              ep_q    <= '0;
            end
            ST_ER: begin
              if (vx_q > vy_q) er_q <= res_neg[15:0];
              else er_q <= (res > ECC_MAX) ? ECC_MAX[15:0] : res[15:0];
            end
            ST_DD:  dd_q <= res;
            ST_EPS, ST_ARS, ST_APS: root_q <= res;
            ST_EPD: ep_q <= (res > ECC_MAX) ? ECC_MAX[14:0] : res[14:0];
            ST_ARM: begin
              ar_q <= area_sat;
              ap_q <= '0;
            end
            ST_APM: ap_q <= area_sat;
            default: ap_q <= ap_q;
          endcase
        end
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign var_x_o            = ovx_q;
  assign var_y_o            = ovy_q;
  assign cov_xy_o           = oc_q;
  assign ecc_reaction_o     = oer_q;
  assign ecc_participant_o  = oep_q;
  assign area_reaction_o    = oar_q;
  assign area_participant_o = oap_q;
  assign point_count_o      = ocnt_q;
  assign degenerate_o       = odeg_q;
  assign overflow_o         = odrop_q;

endmodule

### rtl/core/spatial_eccentricity_moments_unit.sv
// ----------------------------------------------------------------------------
// spatial_eccentricity_moments_unit
// second moment shape of a point set: variances, covariance, eccentricities
// and areas, one result per set closed by the last flag
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// point     in         in_valid_i / in_ready_o       x_i, y_i, last_i
// result    out        out_valid_o / out_ready_i     var_x_o .. overflow_o
// config    in         area_factor_we_i (no wait)    area_factor_i
//
// points are taken one per cycle by the accumulator; a closed set waits in a
// two entry queue for the solver, which handles one set at a time on its shared
// iterative multiply, divide and square root unit.
// the point side stalls only while the queue holds two closed sets.
// reset clears the sums, the queue and the solver; area factor returns to pi.
// ----------------------------------------------------------------------------
module spatial_eccentricity_moments_unit #(
  parameter int unsigned MAX_POINTS = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               area_factor_we_i,
  input  logic [17:0]        area_factor_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [29:0]        var_x_o,
  output logic [29:0]        var_y_o,
  output logic signed [30:0] cov_xy_o,
  output logic signed [15:0] ecc_reaction_o,
  output logic [14:0]        ecc_participant_o,
  output logic [31:0]        area_reaction_o,
  output logic [31:0]        area_participant_o,
  output logic [9:0]         point_count_o,
  output logic               degenerate_o,
  output logic               overflow_o
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 16 + CW;
  localparam int unsigned PW = 32 + CW;
  localparam int unsigned DW = 1 + CW + 2 * SW + 3 * PW;

  logic [17:0] af_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= AREA_FACTOR_RESET;
    end else if (area_factor_we_i) begin
      af_q <= area_factor_i;
    end
  end

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic [CW-1:0]        f_n, b_n;
  logic signed [SW-1:0] f_sx, f_sy, b_sx, b_sy;
  logic signed [PW-1:0] f_sxx, f_syy, f_sxy, b_sxx, b_syy, b_sxy;
  logic                 f_drop, b_drop;
  logic [DW-1:0]        push_data, pop_data;

  sem_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_i          (x_i),
    .y_i          (y_i),
    .last_i       (last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .n_o          (f_n),
    .sx_o         (f_sx),
    .sy_o         (f_sy),
    .sxx_o        (f_sxx),
    .syy_o        (f_syy),
    .sxy_o        (f_sxy),
    .drop_o       (f_drop)
  );

  assign push_data = {f_drop, f_n, f_sx, f_sy, f_sxx, f_syy, f_sxy};

  sem_queue #(.DW(DW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {b_drop, b_n, b_sx, b_sy, b_sxx, b_syy, b_sxy} = pop_data;

  sem_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .set_valid_i        (pop_valid),
    .set_ready_o        (pop_ready),
    .n_i                (b_n),
    .sx_i               (b_sx),
    .sy_i               (b_sy),
    .sxx_i              (b_sxx),
    .syy_i              (b_syy),
    .sxy_i              (b_sxy),
    .drop_i             (b_drop),
    .area_factor_i      (af_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .var_x_o            (var_x_o),
    .var_y_o            (var_y_o),
    .cov_xy_o           (cov_xy_o),
    .ecc_reaction_o     (ecc_reaction_o),
    .ecc_participant_o  (ecc_participant_o),
    .area_reaction_o    (area_reaction_o),
    .area_participant_o (area_participant_o),
    .point_count_o      (point_count_o),
    .degenerate_o       (degenerate_o),
    .overflow_o         (overflow_o)
  );

endmodule

### test/spatial_eccentricity_moments_unit_tb.sv
// ----------------------------------------------------------------------------
// spatial_eccentricity_moments_unit_tb
// streams point sets through the unit under random handshake idling, predicts
// the moments, eccentricities and areas of every closed set and compares each
// result transaction field by field; covers the area factor extremes, the
// capacity limit, degenerate sets and a long result-side hold-off
// ----------------------------------------------------------------------------
module spatial_eccentricity_moments_unit_tb;
  import sem_pkg::*;

  localparam int unsigned Capacity = 512;

  typedef struct packed {
    logic [29:0]        var_x;
    logic [29:0]        var_y;
    logic signed [30:0] cov_xy;
    logic signed [15:0] ecc_r;
    logic [14:0]        ecc_p;
    logic [31:0]        area_r;
    logic [31:0]        area_p;
    logic [9:0]         count;
    logic               degen;
    logic               ovf;
  } shape_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               area_factor_we_i = 1'b0;
  logic [17:0]        area_factor_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] x_i = '0;
  logic signed [15:0] y_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [29:0]        var_x_o;
  logic [29:0]        var_y_o;
  logic signed [30:0] cov_xy_o;
  logic signed [15:0] ecc_reaction_o;
  logic [14:0]        ecc_participant_o;
  logic [31:0]        area_reaction_o;
  logic [31:0]        area_participant_o;
  logic [9:0]         point_count_o;
  logic               degenerate_o;
  logic               overflow_o;

  spatial_eccentricity_moments_unit #(.MAX_POINTS(Capacity)) i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [17:0] pi_factor;
  int unsigned pts_n;
  longint      s_x, s_y, s_xx, s_yy, s_xy;
  bit          pts_dropped;
  shape_t      shape_q[$];
  int          errors = 0;
  int          points_sent = 0;
  bit          idling = 1'b1;
  bit          long_hold = 1'b0;
  int          hold_off = 0;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t <= v / t) r = t;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned scaled_area(longint unsigned rad);
    longint unsigned a;
    a = (floor_root(rad) * longint'(pi_factor)) >> AREA_SHIFT;
    return a > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : a;
  endfunction

  function automatic void absorb_point(logic signed [15:0] px, py, logic fin);
    longint n, n2, vx, vy, c, sum, rad_pp;
    longint unsigned d;
    shape_t s;
    if (pts_n < Capacity) begin
      pts_n++;
      s_x += px; s_y += py;
      s_xx += longint'(px) * px; s_yy += longint'(py) * py; s_xy += longint'(px) * py;
    end else pts_dropped = 1'b1;
    if (!fin) return;
    n = pts_n;
    n2 = n * n;
    vx = 0; vy = 0; c = 0;
    if (n2 != 0) begin
      vx = clip((n * s_xx - s_x * s_x) / n2, 0, VAR_MAX);
      vy = clip((n * s_yy - s_y * s_y) / n2, 0, VAR_MAX);
      c = clip((n * s_xy - s_x * s_y) / n2, -longint'(COV_MIN_MAG), COV_MAX);
    end
    sum = vx + vy;
    s = '0;
    s.degen = (sum == 0);
    if (!s.degen) begin
      s.ecc_r = 16'(clip(((vy - vx) * 32768) / sum, -32768, 32767));
      d = vx > vy ? vx - vy : vy - vx;
      s.ecc_p = 15'(clip(longint'((floor_root(d * d + 4 * c * c) << ECC_SHIFT) / sum),
                         0, ECC_MAX));
    end
    rad_pp = vx * vy - c * c;
    s.var_x = 30'(vx);
    s.var_y = 30'(vy);
    s.cov_xy = 31'(c);
    s.area_r = 32'(scaled_area(vx * vy));
    s.area_p = rad_pp > 0 ? 32'(scaled_area(rad_pp)) : '0;
    s.count = 10'(pts_n);
    s.ovf = pts_dropped;
    shape_q = {shape_q, s};
    pts_n = 0; s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0; pts_dropped = 0;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result side
  always @(negedge clk_i) begin
    if (long_hold) begin
      long_hold = 1'b0;
      hold_off <= 2999;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    shape_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shape_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = shape_q.pop_front();
        if (var_x_o != w.var_x) report("var_x", var_x_o, w.var_x);
        if (var_y_o != w.var_y) report("var_y", var_y_o, w.var_y);
        if (cov_xy_o != w.cov_xy) report("cov_xy", cov_xy_o, w.cov_xy);
        if (ecc_reaction_o != w.ecc_r) report("ecc_reaction", ecc_reaction_o, w.ecc_r);
        if (ecc_participant_o != w.ecc_p) report("ecc_participant", ecc_participant_o, w.ecc_p);
        if (area_reaction_o != w.area_r) report("area_reaction", area_reaction_o, w.area_r);
        if (area_participant_o != w.area_p)
          report("area_participant", area_participant_o, w.area_p);
        if (point_count_o != w.count) report("point_count", point_count_o, w.count);
        if (degenerate_o != w.degen) report("degenerate", degenerate_o, w.degen);
        if (overflow_o != w.ovf) report("overflow", overflow_o, w.ovf);
      end
    end
  end

  // point side
  task automatic send_point(logic signed [15:0] px, py, logic fin);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    x_i <= px; y_i <= py; last_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_point(px, py, fin);
    points_sent++;
  endtask

  function automatic logic signed [15:0] coord(int centre, int spread);
    return 16'(clip(centre + $signed($urandom_range(0, 2 * spread)) - spread, -32768, 32767));
  endfunction

  task automatic send_set(int len, bit wide);
    int cx, cy, sp;
    cx = $signed($urandom_range(0, 65535)) - 32768;
    cy = $signed($urandom_range(0, 65535)) - 32768;
    sp = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 4000);
    for (int i = 0; i < len; i++)
      if (wide) send_point(16'($urandom), 16'($urandom), i == len - 1);
      else send_point(coord(cx, sp), coord(cy, sp), i == len - 1);
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (shape_q.size() == 0);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic set_area_factor(logic [17:0] f);
    @(negedge clk_i);
    area_factor_we_i <= 1'b1;
    area_factor_i <= f;
    @(negedge clk_i) area_factor_we_i <= 1'b0;
    pi_factor = f;
  endtask

  task automatic test_directed_shapes();
    send_point(16'sh7FFF, -16'sh8000, 1'b1);
    send_point(-16'sh8000, -16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_point(-16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, -16'sh8000, 1'b1);
    repeat (3) send_point(16'sh0123, -16'sh0456, 1'b0);
    send_point(16'sh0123, -16'sh0456, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(2, 2, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1, 2, 1'b0);
    send_point(3, 5, 1'b1);
    send_point(-16'sh8000, 0, 1'b0);
    send_point(16'sh7FFF, 0, 1'b1);
    send_point(0, -16'sh8000, 1'b0);
    send_point(0, 16'sh7FFF, 1'b1);
    send_point(16'sh5555, 16'shAAAA, 1'b0);
    send_point(16'shAAAA, 16'sh5555, 1'b1);
  endtask

  task automatic test_area_factor_sweep();
    logic [17:0] f[4] = '{18'd0, 18'h3FFFF, 18'd1, AREA_FACTOR_RESET};
    foreach (f[i]) begin
      drain();
      set_area_factor(f[i]);
      send_set(2, 1'b1);
      send_set(5, 1'b1);
      send_set(8, 1'b0);
    end
    drain();
    set_area_factor(18'($urandom));
  endtask

  task automatic test_capacity_overflow();
    send_set(Capacity, 1'b1);
    send_set(Capacity + 9, 1'b0);
  endtask

  task automatic test_random_sets();
    int target;
    target = points_sent + 180;
    while (points_sent < target)
      send_set($urandom_range(0, 7) == 0 ? $urandom_range(25, 80) : $urandom_range(1, 24),
               $urandom_range(0, 3) == 0);
  endtask

  task automatic test_backpressure();
    drain();
    long_hold = 1'b1;
    repeat (12) send_set($urandom_range(1, 4), 1'b1);
  endtask

  task automatic test_drain_pause();
    drain();
    repeat (4) send_set($urandom_range(2, 10), 1'b0);
  endtask

  task automatic test_final_stream();
    idling = 1'b0;
    repeat (12) send_set($urandom_range(1, 16), $urandom_range(0, 1));
  endtask

  initial begin
    pi_factor = AREA_FACTOR_RESET;
    pts_n = 0; s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0; pts_dropped = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed_shapes();
    test_area_factor_sweep();
    test_capacity_overflow();
    test_random_sets();
    test_backpressure();
    test_drain_pause();
    test_final_stream();
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (shape_q.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0) $display("spatial_eccentricity_moments_unit_tb: clean");
    else $display("spatial_eccentricity_moments_unit_tb: errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("spatial_eccentricity_moments_unit_tb: errors");
    $finish;
  end

endmodule
